// ----- rtl/mtes_pkg.sv -----
// Shared types, constants and helper functions of the MIDI track event serializer.
package mtes_pkg;

    localparam int REQ_W  = 2;
    localparam int TIME_W = 28;
    localparam int BYTE_W = 8;
    localparam int PLEN_W = 14;
    localparam int LEN_W  = 32;

    localparam int VLQ_W      = 28;
    localparam int VLQ_DIGIT  = 7;
    localparam int VLQ_GROUPS = (VLQ_W + VLQ_DIGIT - 1) / VLQ_DIGIT;
    localparam int VLQ_GRP_W  = $clog2(VLQ_GROUPS);

    localparam int QUEUE_DEPTH = 4;

    localparam logic [REQ_W-1:0] REQ_EVENT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PAYLOAD = 2'd1;
    localparam logic [REQ_W-1:0] REQ_END     = 2'd2;

    localparam logic [BYTE_W-1:0] SYSTEM_STATUS = 8'hF0;
    localparam logic [BYTE_W-1:0] META_STATUS   = 8'hFF;
    localparam logic [BYTE_W-1:0] END_OF_TRACK  = 8'h2F;
    localparam logic [BYTE_W-1:0] ZERO_BYTE     = 8'h00;

    typedef enum logic [1:0] {
        JOB_EVENT,
        JOB_PAYLOAD,
        JOB_END
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [VLQ_W-1:0]   delta;
        logic               has_status;
        logic [BYTE_W-1:0]  status;
        logic               has_d0;
        logic [BYTE_W-1:0]  d0;
        logic               has_d1;
        logic [BYTE_W-1:0]  d1;
        logic               has_plen;
        logic [VLQ_W-1:0]   plen;
    } t_job;

    function automatic logic [VLQ_GRP_W-1:0] vlq_top_group(input logic [VLQ_W-1:0] value);
        logic [VLQ_GRP_W-1:0] grp;
        grp = '0;
        for (int g = 1; g < VLQ_GROUPS; g++) begin
            if ((value >> (VLQ_DIGIT * g)) != '0) begin
                grp = VLQ_GRP_W'(g);
            end
        end
        return grp;
    endfunction

    function automatic logic [BYTE_W-1:0] vlq_byte(input logic [VLQ_W-1:0] value,
                                                  input logic [VLQ_GRP_W-1:0] grp);
        logic [VLQ_W-1:0] shifted;
        shifted = value >> (VLQ_DIGIT * int'(grp));
        return {grp != '0, shifted[VLQ_DIGIT-1:0]};
    endfunction

endpackage

// ----- rtl/mtes_in_if.sv -----
// Request channel carrying one event header, payload byte or end of track.
interface mtes_in_if;
    import mtes_pkg::*;

    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [TIME_W-1:0]   event_time;
    logic [BYTE_W-1:0]   status_byte;
    logic [BYTE_W-1:0]   data_first;
    logic [BYTE_W-1:0]   data_second;
    logic [PLEN_W-1:0]   payload_length;
    logic [BYTE_W-1:0]   payload_byte;

    modport source (
        output valid, req_type, event_time, status_byte, data_first, data_second,
               payload_length, payload_byte,
        input  ready
    );

    modport sink (
        input  valid, req_type, event_time, status_byte, data_first, data_second,
               payload_length, payload_byte,
        output ready
    );
endinterface

// ----- rtl/mtes_out_if.sv -----
// Byte channel carrying the track body one byte per transaction.
interface mtes_out_if;
    import mtes_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_byte;
    logic                last_of_run;
    logic [LEN_W-1:0]    track_length;

    modport source (
        output valid, out_byte, last_of_run, track_length,
        input  ready
    );

    modport sink (
        input  valid, out_byte, last_of_run, track_length,
        output ready
    );
endinterface

// ----- rtl/midi_track_event_serializer.sv -----
// Top level of the MIDI track event serializer with running status.
//
//   Channel   Direction  Modport  Contents
//   i_req     in         sink     req_type, event_time, status, data, payload fields
//   o_evt     out        source   out_byte, last_of_run, track_length
//
// The output carries one byte per cycle while the receiver is ready; a request produces from one
// byte for a payload byte up to eight bytes for a meta event.
// A four-entry job queue lets the front end accept requests while the serializer works.
// Synchronous active-low reset clears the time, running status, byte count and queue.
// A stalled output holds its byte; the serializer and then the front end stall behind it.
module midi_track_event_serializer #(
    parameter int TIME_BITS        = 28,
    parameter int MAX_PAYLOAD_BITS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mtes_in_if.sink     i_req,
    mtes_out_if.source  o_evt
);
    import mtes_pkg::*;

    logic push;
    logic full;
    logic head_valid;
    logic pop;
    t_job push_job;
    t_job head;

    mtes_front #(
        .TIME_BITS        (TIME_BITS),
        .MAX_PAYLOAD_BITS (MAX_PAYLOAD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    mtes_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_job   (push_job),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    mtes_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_evt        (o_evt)
    );
endmodule

// ----- rtl/mtes_front.sv -----
// Front end: accepts requests, computes delta time and running status, builds jobs.
module mtes_front #(
    parameter int TIME_BITS        = 28,
    parameter int MAX_PAYLOAD_BITS = 14
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mtes_in_if.sink        i_req,
    input  logic           i_full,
    output logic           o_push,
    output mtes_pkg::t_job o_job
);
    import mtes_pkg::*;

    localparam logic [VLQ_W-1:0] PLEN_MASK = VLQ_W'((64'd1 << MAX_PAYLOAD_BITS) - 64'd1);

    logic [TIME_BITS-1:0] r_prev_time;
    logic [BYTE_W-1:0]    r_running;
    logic [TIME_BITS-1:0] cur_time;
    logic [TIME_BITS-1:0] delta;
    logic                 accept;

    assign i_req.ready = !i_full;
    assign accept      = i_req.valid && i_req.ready;
    assign cur_time    = i_req.event_time[TIME_BITS-1:0];
    assign delta       = (cur_time > r_prev_time) ? (cur_time - r_prev_time) : '0;

    always_comb begin
        o_job            = '0;
        o_job.kind       = JOB_EVENT;
        o_job.delta      = VLQ_W'(delta);
        o_job.status     = i_req.status_byte;
        o_job.d0         = i_req.data_first;
        o_job.d1         = i_req.data_second;
        o_job.plen       = VLQ_W'(i_req.payload_length) & PLEN_MASK;
        o_job.has_status = (i_req.status_byte != r_running) ||
                           (i_req.status_byte >= SYSTEM_STATUS);
        unique case (i_req.status_byte[7:4])
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: begin
                o_job.has_d0 = 1'b1;
                o_job.has_d1 = 1'b1;
            end
            4'hC, 4'hD: begin
                o_job.has_d0 = 1'b1;
            end
            4'hF: begin
                o_job.has_d0   = (i_req.status_byte == META_STATUS);
                o_job.has_plen = 1'b1;
            end
            default: begin
            end
        endcase
        if (i_req.req_type == REQ_PAYLOAD) begin
            o_job.kind = JOB_PAYLOAD;
            o_job.d0   = i_req.payload_byte;
        end else if (i_req.req_type == REQ_END) begin
            o_job.kind = JOB_END;
        end
    end

    assign o_push = accept && ((i_req.req_type == REQ_EVENT) ||
                               (i_req.req_type == REQ_PAYLOAD) ||
                               (i_req.req_type == REQ_END));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time <= '0;
            r_running   <= '0;
        end else if (accept) begin
            if (i_req.req_type == REQ_EVENT) begin
                r_prev_time <= cur_time;
                r_running   <= i_req.status_byte;
            end else if (i_req.req_type == REQ_END) begin
                r_prev_time <= '0;
                r_running   <= '0;
            end
        end
    end
endmodule

// ----- rtl/mtes_queue.sv -----
// Short job queue between the front end and the byte serializer.
module mtes_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mtes_pkg::t_job i_push_job,
    output logic           o_full,
    output logic           o_head_valid,
    output mtes_pkg::t_job o_head,
    input  logic           i_pop
);
    import mtes_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("Job pushed into a full queue.");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("Job popped from an empty queue.");
endmodule

// ----- rtl/mtes_back.sv -----
// Back end: walks the head job byte by byte and drives the registered byte output.
module mtes_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  mtes_pkg::t_job i_head,
    output logic           o_pop,
    mtes_out_if.source     o_evt
);
    import mtes_pkg::*;

    typedef enum logic [3:0] {
        SEG_DELTA,
        SEG_STATUS,
        SEG_DATA0,
        SEG_DATA1,
        SEG_PLEN,
        SEG_META,
        SEG_EOT,
        SEG_ZERO,
        SEG_PAYLOAD
    } t_seg;

    logic                 r_started;
    t_seg                 r_seg;
    logic [VLQ_GRP_W-1:0] r_grp;
    logic                 r_out_valid;
    logic [BYTE_W-1:0]    r_out_byte;
    logic                 r_out_last;
    logic [LEN_W-1:0]     r_out_len;
    logic [LEN_W-1:0]     r_count;

    t_seg                 cur_seg;
    t_seg                 n_seg;
    logic [VLQ_GRP_W-1:0] cur_grp;
    logic [VLQ_GRP_W-1:0] n_grp;
    logic [BYTE_W-1:0]    cur_byte;
    logic                 cur_last;
    logic                 fire;
    logic                 end_done;

    always_comb begin
        if (r_started) begin
            cur_seg = r_seg;
            cur_grp = r_grp;
        end else begin
            cur_seg = (i_head.kind == JOB_PAYLOAD) ? SEG_PAYLOAD : SEG_DELTA;
            cur_grp = vlq_top_group(i_head.delta);
        end
        n_seg    = cur_seg;
        n_grp    = cur_grp;
        cur_byte = ZERO_BYTE;
        cur_last = 1'b0;
        unique case (cur_seg)
            SEG_DELTA: begin
                cur_byte = vlq_byte(i_head.delta, cur_grp);
                priority if (cur_grp != '0) begin
                    n_grp = cur_grp - 1'b1;
                end else if (i_head.kind == JOB_END) begin
                    n_seg = SEG_META;
                end else if (i_head.has_status) begin
                    n_seg = SEG_STATUS;
                end else if (i_head.has_d0) begin
                    n_seg = SEG_DATA0;
                end else if (i_head.has_plen) begin
                    n_seg = SEG_PLEN;
                    n_grp = vlq_top_group(i_head.plen);
                end else begin
                    cur_last = 1'b1;
                end
            end
            SEG_STATUS: begin
                cur_byte = i_head.status;
                priority if (i_head.has_d0) begin
                    n_seg = SEG_DATA0;
                end else if (i_head.has_plen) begin
                    n_seg = SEG_PLEN;
                    n_grp = vlq_top_group(i_head.plen);
                end else begin
                    cur_last = 1'b1;
                end
            end
            SEG_DATA0: begin
                cur_byte = i_head.d0;
                priority if (i_head.has_d1) begin
                    n_seg = SEG_DATA1;
                end else if (i_head.has_plen) begin
                    n_seg = SEG_PLEN;
                    n_grp = vlq_top_group(i_head.plen);
                end else begin
                    cur_last = 1'b1;
                end
            end
            SEG_DATA1: begin
                cur_byte = i_head.d1;
                cur_last = 1'b1;
            end
            SEG_PLEN: begin
                cur_byte = vlq_byte(i_head.plen, cur_grp);
                if (cur_grp != '0) begin
                    n_grp = cur_grp - 1'b1;
                end else begin
                    cur_last = 1'b1;
                end
            end
            SEG_META: begin
                cur_byte = META_STATUS;
                n_seg    = SEG_EOT;
            end
            SEG_EOT: begin
                cur_byte = END_OF_TRACK;
                n_seg    = SEG_ZERO;
            end
            SEG_ZERO: begin
                cur_byte = ZERO_BYTE;
                cur_last = 1'b1;
            end
            SEG_PAYLOAD: begin
                cur_byte = i_head.d0;
                cur_last = 1'b1;
            end
            default: begin
                cur_last = 1'b1;
            end
        endcase
    end

    assign fire     = i_head_valid && (!r_out_valid || o_evt.ready);
    assign o_pop    = fire && cur_last;
    assign end_done = o_pop && (i_head.kind == JOB_END);

    assign o_evt.valid        = r_out_valid;
    assign o_evt.out_byte     = r_out_byte;
    assign o_evt.last_of_run  = r_out_last;
    assign o_evt.track_length = r_out_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else if (fire) begin
            r_started   <= !cur_last;
            r_seg       <= n_seg;
            r_grp       <= n_grp;
            r_out_valid <= 1'b1;
            r_out_byte  <= cur_byte;
            r_out_last  <= cur_last;
            if (end_done) begin
                r_out_len <= r_count + 1'b1;
                r_count   <= '0;
            end else begin
                r_out_len <= '0;
                r_count   <= r_count + 1'b1;
            end
        end else if (o_evt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    a_length_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_len != '0)) |-> r_out_last)
        else $error("Track length reported on a byte that does not close its run.");

    a_count_cleared_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        end_done |=> (r_count == '0))
        else $error("Byte count not cleared after the end of track.");

    a_pop_on_last_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_out_valid && r_out_last && !r_started))
        else $error("Job popped without closing its byte run.");
endmodule

// ----- sim/tb_midi_track_event_serializer.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the MIDI track serializer: directed table, random tracks, stalls.
module tb_midi_track_event_serializer;
    import mtes_pkg::*;

    localparam int RAND_ITEMS  = 470;
    localparam int DIR_ROWS    = 25;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN       = 30;
    localparam int LIMIT       = 200000;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam logic [3:0] NOTE_OFF         = 4'h8;
    localparam logic [3:0] NOTE_ON          = 4'h9;
    localparam logic [3:0] POLY_PRESSURE    = 4'hA;
    localparam logic [3:0] CONTROL_CHANGE   = 4'hB;
    localparam logic [3:0] PROGRAM_CHANGE   = 4'hC;
    localparam logic [3:0] CHANNEL_PRESSURE = 4'hD;
    localparam logic [3:0] PITCH_BEND       = 4'hE;
    localparam logic [3:0] SYSTEM_CLASS     = 4'hF;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [TIME_W-1:0] tick;
        logic [BYTE_W-1:0] status;
        logic [BYTE_W-1:0] d0;
        logic [BYTE_W-1:0] d1;
        logic [PLEN_W-1:0] plen;
        logic [BYTE_W-1:0] pbyte;
    } t_request;

    typedef struct packed {
        t_request         rq;
        logic [3:0]       exp_n;
        logic [79:0]      exp_bytes;
        logic [LEN_W-1:0] exp_len;
    } t_dir_row;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [LEN_W-1:0]  length;
    } t_body_byte;

    logic i_clk;
    logic i_rst_n;

    mtes_in_if  req_if();
    mtes_out_if evt_if();

    midi_track_event_serializer u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_evt  (evt_if)
    );

    t_dir_row dir_tab [DIR_ROWS] = '{
        '{'{REQ_END,     28'd0,       8'h00, 8'h00, 8'h00, 14'h0,    8'h00},
          4'd4, 80'h00FF2F00, 32'd4},
        '{'{REQ_EVENT,   28'd0,       8'h90, 8'h3C, 8'h64, 14'h0,    8'h00},
          4'd4, 80'h00903C64, 32'd0},
        '{'{REQ_EVENT,   28'hFFFFFFF, 8'h90, 8'hFF, 8'h00, 14'h0,    8'h00},
          4'd6, 80'hFFFFFF7FFF00, 32'd0},
        '{'{REQ_EVENT,   28'd0,       8'h80, 8'h00, 8'h7F, 14'h0,    8'h00},
          4'd4, 80'h0080007F, 32'd0},
        '{'{REQ_EVENT,   28'd5,       8'hC3, 8'h7F, 8'h00, 14'h0,    8'h00}, 4'd0, 80'h0, 32'd0},
        '{'{REQ_EVENT,   28'd5,       8'hD0, 8'h01, 8'h00, 14'h0,    8'h00}, 4'd0, 80'h0, 32'd0},
        '{'{REQ_EVENT,   28'd133,     8'hA1, 8'h11, 8'h22, 14'h0,    8'h00}, 4'd0, 80'h0, 32'd0},
        '{'{REQ_EVENT,   28'd200,     8'hB2, 8'h07, 8'h7F, 14'h0,    8'h00}, 4'd0, 80'h0, 32'd0},
        '{'{REQ_EVENT,   28'd200,     8'hE0, 8'h00, 8'h40, 14'h0,    8'h00}, 4'd0, 80'h0, 32'd0},
        '{'{REQ_EVENT,   28'd300,     8'hF0, 8'h00, 8'h00, 14'd3,    8'h00}, 4'd0, 80'h0, 32'd0},
        '{'{REQ_PAYLOAD, 28'd0,       8'h00, 8'h00, 8'h00, 14'h0,    8'h00}, 4'd0, 80'h0, 32'd0},
        '{'{REQ_PAYLOAD, 28'd0,       8'h00, 8'h00, 8'h00, 14'h0,    8'hFF}, 4'd0, 80'h0, 32'd0},
        '{'{REQ_PAYLOAD, 28'd0,       8'h00, 8'h00, 8'h00, 14'h0,    8'hA5}, 4'd0, 80'h0, 32'd0},
        '{'{REQ_EVENT,   28'd300,     8'hFF, 8'h51, 8'h00, 14'h3FFF, 8'h00}, 4'd0, 80'h0, 32'd0},
        '{'{REQ_EVENT,   28'd301,     8'hFF, 8'h2F, 8'h00, 14'h0,    8'h00}, 4'd0, 80'h0, 32'd0},
        '{'{REQ_EVENT,   28'd302,     8'hF7, 8'h00, 8'h00, 14'h0,    8'h00}, 4'd0, 80'h0, 32'd0},
        '{'{REQ_EVENT,   28'd310,     8'h05, 8'h12, 8'h34, 14'h0,    8'h00}, 4'd0, 80'h0, 32'd0},
        '{'{REQ_EVENT,   28'd320,     8'h05, 8'h12, 8'h34, 14'h0,    8'h00}, 4'd0, 80'h0, 32'd0},
        '{'{REQ_EVENT,   28'd330,     8'h90, 8'h40, 8'h00, 14'h0,    8'h00}, 4'd0, 80'h0, 32'd0},
        '{'{REQ_UNUSED,  28'hFFFFFFF, 8'hFF, 8'hFF, 8'hFF, 14'h3FFF, 8'hFF}, 4'd0, 80'h0, 32'd0},
        '{'{REQ_PAYLOAD, 28'd0,       8'h00, 8'h00, 8'h00, 14'h0,    8'h5A}, 4'd0, 80'h0, 32'd0},
        '{'{REQ_END,     28'd10,      8'h00, 8'h00, 8'h00, 14'h0,    8'h00}, 4'd0, 80'h0, 32'd0},
        '{'{REQ_END,     28'd0,       8'h00, 8'h00, 8'h00, 14'h0,    8'h00},
          4'd4, 80'h00FF2F00, 32'd4},
        '{'{REQ_END,     28'hFFFFFFF, 8'h00, 8'h00, 8'h00, 14'h0,    8'h00},
          4'd7, 80'hFFFFFF7FFF2F00, 32'd7},
        '{'{REQ_EVENT,   28'h3FFF,    8'h00, 8'hFF, 8'hFF, 14'h3FFF, 8'h00},
          4'd2, 80'hFF7F, 32'd0}
    };

    logic [TIME_W-1:0] trk_prev;
    logic [BYTE_W-1:0] trk_status;
    logic [LEN_W-1:0]  trk_count;
    t_body_byte        run_buf [10];
    int                run_n;
    t_body_byte        body_due [$];

    logic [TIME_W-1:0] gen_time;
    logic [BYTE_W-1:0] gen_status;
    int                send_idle_pct;
    int                recv_idle_pct;
    bit                hold_req;
    int                hold_left;

    int          n_sent;
    int          n_accepted;
    int          n_tracks;
    int          n_checked;
    int          n_errors;
    int          stall_run;
    int          stall_max;
    int unsigned n_cycles;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void put_byte(input logic [BYTE_W-1:0] b);
        run_buf[run_n] = '{b, 1'b0, LEN_W'(0)};
        run_n++;
        trk_count++;
    endfunction

    function automatic void put_vlq(input logic [TIME_W-1:0] v);
        int groups;
        groups = 1;
        while (groups < 4 && (v >> (7 * groups)) != '0) groups++;
        for (int g = groups - 1; g >= 0; g--) begin
            put_byte({g != 0, 7'(v >> (7 * g))});
        end
    endfunction

    function automatic void encode_request(input t_request rq);
        logic [TIME_W-1:0] delta;
        run_n = 0;
        delta = (rq.tick > trk_prev) ? rq.tick - trk_prev : '0;
        case (rq.req)
            REQ_EVENT: begin
                put_vlq(delta);
                trk_prev = rq.tick;
                if (rq.status != trk_status || rq.status >= SYSTEM_STATUS) put_byte(rq.status);
                trk_status = rq.status;
                case (rq.status[7:4])
                    NOTE_OFF, NOTE_ON, POLY_PRESSURE, CONTROL_CHANGE, PITCH_BEND: begin
                        put_byte(rq.d0);
                        put_byte(rq.d1);
                    end
                    PROGRAM_CHANGE, CHANNEL_PRESSURE: begin
                        put_byte(rq.d0);
                    end
                    SYSTEM_CLASS: begin
                        if (rq.status == META_STATUS) put_byte(rq.d0);
                        put_vlq(TIME_W'(rq.plen));
                    end
                    default: begin
                    end
                endcase
            end
            REQ_PAYLOAD: begin
                put_byte(rq.pbyte);
            end
            REQ_END: begin
                put_vlq(delta);
                put_byte(META_STATUS);
                put_byte(END_OF_TRACK);
                put_byte(ZERO_BYTE);
                run_buf[run_n-1].length = trk_count;
                trk_prev   = '0;
                trk_status = '0;
                trk_count  = '0;
            end
            default: begin
            end
        endcase
        if (run_n != 0) run_buf[run_n-1].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_request   rq;
        t_dir_row   row;
        t_body_byte want;
        t_body_byte got;
        n_cycles++;
        if (n_cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else if (i_rst_n) begin
            if (req_if.valid && !req_if.ready) begin
                stall_run++;
                if (stall_run > stall_max) stall_max = stall_run;
            end else begin
                stall_run = 0;
            end
            if (req_if.valid && req_if.ready) begin
                rq = '{req_if.req_type, req_if.event_time, req_if.status_byte,
                       req_if.data_first, req_if.data_second, req_if.payload_length,
                       req_if.payload_byte};
                encode_request(rq);
                row = (n_accepted < DIR_ROWS) ? dir_tab[n_accepted] : '0;
                if (row.exp_n != 0) begin
                    for (int k = 0; k < int'(row.exp_n); k++) begin
                        want.data   = 8'(row.exp_bytes >> (8 * (int'(row.exp_n) - 1 - k)));
                        want.last   = (k == int'(row.exp_n) - 1);
                        want.length = want.last ? row.exp_len : '0;
                        body_due.insert(body_due.size(), want);
                    end
                end else begin
                    for (int k = 0; k < run_n; k++) body_due.insert(body_due.size(), run_buf[k]);
                end
                if (rq.req == REQ_END) n_tracks++;
                n_accepted++;
            end
            if (evt_if.valid && evt_if.ready) begin
                got = '{evt_if.out_byte, evt_if.last_of_run, evt_if.track_length};
                if (body_due.size() == 0) begin
                    $error("unexpected body byte %02h with nothing pending", got.data);
                    n_errors++;
                end else begin
                    want = body_due.pop_front();
                    if (got.data !== want.data) begin
                        $error("out_byte: expected %02h, got %02h", want.data, got.data);
                        n_errors++;
                    end
                    if (got.last !== want.last) begin
                        $error("last_of_run: expected %0b, got %0b", want.last, got.last);
                        n_errors++;
                    end
                    if (got.length !== want.length) begin
                        $error("track_length: expected %0d, got %0d", want.length, got.length);
                        n_errors++;
                    end
                end
                n_checked++;
            end
        end
    end

    initial begin : receiver
        evt_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                evt_if.ready <= 1'b0;
                hold_left--;
            end else begin
                evt_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic put_fields(input t_request rq);
        req_if.req_type       <= rq.req;
        req_if.event_time     <= rq.tick;
        req_if.status_byte    <= rq.status;
        req_if.data_first     <= rq.d0;
        req_if.data_second    <= rq.d1;
        req_if.payload_length <= rq.plen;
        req_if.payload_byte   <= rq.pbyte;
    endtask

    function automatic t_request random_request(input logic [REQ_W-1:0] req);
        logic [95:0] raw;
        t_request    rq;
        raw    = {$urandom, $urandom, $urandom};
        rq     = raw[$bits(t_request)-1:0];
        rq.req = req;
        return rq;
    endfunction

    task automatic send_request(input t_request rq);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            put_fields(random_request(REQ_W'($urandom)));
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        put_fields(rq);
        do @(posedge i_clk); while (!req_if.ready);
        if (rq.req != REQ_UNUSED) n_sent++;
    endtask

    function automatic logic [TIME_W-1:0] next_tick();
        int r;
        r = $urandom_range(99);
        if (r < 5) return TIME_W'($urandom);
        if (r < 10) return gen_time - TIME_W'($urandom_range(0, 50));
        if (r < 20) return gen_time + TIME_W'($urandom_range(0, 1 << 21));
        return gen_time + TIME_W'($urandom_range(0, 200));
    endfunction

    function automatic logic [BYTE_W-1:0] midi_data();
        return ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
    endfunction

    task automatic send_event_message();
        t_request rq;
        int       r;
        int       n_pay;
        rq      = random_request(REQ_EVENT);
        rq.tick = next_tick();
        r       = $urandom_range(99);
        if (r < 30) rq.status = gen_status;
        else if (r < 75) rq.status = 8'($urandom_range(128, 239));
        else if (r < 85) rq.status = ($urandom_range(1) != 0) ? META_STATUS : SYSTEM_STATUS;
        else if (r < 92) rq.status = 8'($urandom_range(240, 255));
        else rq.status = 8'($urandom_range(0, 127));
        rq.d0   = midi_data();
        rq.d1   = midi_data();
        rq.plen = ($urandom_range(19) == 0) ? PLEN_W'($urandom) : PLEN_W'($urandom_range(0, 5));
        gen_time   = rq.tick;
        gen_status = rq.status;
        send_request(rq);
        if (rq.status >= SYSTEM_STATUS) begin
            n_pay = (rq.plen > 5) ? $urandom_range(0, 3) : int'(rq.plen);
            if ($urandom_range(9) == 0) n_pay = n_pay + 1;
            repeat (n_pay) send_request(random_request(REQ_PAYLOAD));
        end
    endtask

    initial begin : stimulus
        t_request rq;
        int       r;
        int       phase;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        put_fields('0);
        trk_prev        = '0;
        trk_status      = '0;
        trk_count       = '0;
        run_n           = 0;
        gen_time        = '0;
        gen_status      = '0;
        send_idle_pct   = 12;
        recv_idle_pct   = 67;
        hold_req        = 1'b0;
        hold_left       = 0;
        n_sent          = 0;
        n_accepted      = 0;
        n_tracks        = 0;
        n_checked       = 0;
        n_errors        = 0;
        stall_run       = 0;
        stall_max       = 0;
        n_cycles        = 0;
        phase           = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) send_request(dir_tab[i].rq);

        n_sent = 0;
        while (n_sent < RAND_ITEMS) begin
            if (phase == 0 && n_sent >= RAND_ITEMS / 3) begin
                phase         = 1;
                send_idle_pct = 67;
                recv_idle_pct = 12;
            end else if (phase == 1 && n_sent >= 2 * RAND_ITEMS / 3) begin
                phase         = 2;
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_req      = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 6) begin
                rq      = random_request(REQ_END);
                rq.tick = next_tick();
                send_request(rq);
                gen_time   = '0;
                gen_status = '0;
            end else if (r < 9) begin
                send_request(random_request(($urandom_range(1) != 0) ? REQ_UNUSED : REQ_PAYLOAD));
            end else begin
                send_event_message();
            end
        end
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (body_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("Run covered %0d requests, %0d track ends and %0d checked body bytes.",
                 n_accepted, n_tracks, n_checked);
        $display("Requests were held back for up to %0d cycles by output backpressure.",
                 stall_max);
        if (n_errors == 0 && body_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
